@@ rtl/huff_pkg.sv @@
package huff_pkg;

    localparam int TREE_NODES_DEF = 256;
    localparam int ENTRY_W        = 18;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [8:0]  ROOT_NODE      = 9'h100;
    localparam logic [7:0]  GLYPH_LEAD     = 8'hEF;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [15:0] MAX_LENGTH_RST = 16'hFFFF;

    localparam logic [1:0] KIND_TREE  = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    typedef enum logic [1:0] {
        OP_TREE,
        OP_BYTE,
        OP_START
    } t_op;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] node_slot;
        logic [8:0] zero_child;
        logic [8:0] one_child;
        logic [7:0] stream_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       status;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic [7:0] node_slot;
        logic [8:0] zero_child;
        logic [8:0] one_child;
        logic [7:0] stream_byte;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res_chan;

endpackage

@@ rtl/huff_ram.sv @@
module huff_ram
    #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
    )
    (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/huff_front.sv @@
module huff_front
    import huff_pkg::*;
    (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_in,
    output logic      o_full,
    output t_cmd_chan o_cmd,
    input  logic      i_cmd_pop
    );

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;
    logic [CW-1:0] n_cnt;
    t_cmd          w_cmd;
    logic          w_wr;
    logic          w_rd;

    always_comb begin
        w_cmd.node_slot   = i_in.node_slot;
        w_cmd.zero_child  = i_in.zero_child;
        w_cmd.one_child   = i_in.one_child;
        w_cmd.stream_byte = i_in.stream_byte;
        unique case (i_in.kind)
            KIND_TREE: begin
                w_cmd.op = OP_TREE;
            end
            KIND_BYTE: begin
                w_cmd.op = OP_BYTE;
            end
            default: begin
                w_cmd.op = OP_START;
            end
        endcase
    end

    // Items of the reserved kind are taken and dropped here.
    assign o_full = (r_cnt == CW'(QUEUE_DEPTH));
    assign w_wr   = i_push && !o_full && (i_in.kind != KIND_RSVD);
    assign w_rd   = i_cmd_pop && (r_cnt != '0);

    always_comb begin
        n_wptr = w_wr ? PW'(r_wptr + 1'b1) : r_wptr;
        n_rptr = w_rd ? PW'(r_rptr + 1'b1) : r_rptr;
        unique case ({w_wr, w_rd})
            2'b10: begin
                n_cnt = CW'(r_cnt + 1'b1);
            end
            2'b01: begin
                n_cnt = CW'(r_cnt - 1'b1);
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
        if (w_wr) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.cmd   = r_q[r_rptr];

endmodule

@@ rtl/huff_walk.sv @@
module huff_walk
    import huff_pkg::*;
    #(
    parameter int TREE_NODES = TREE_NODES_DEF
    )
    (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_max_length,
    input  t_cmd_chan   i_cmd,
    output logic        o_cmd_pop,
    output t_res_chan   o_res,
    input  logic        i_res_full
    );

    localparam int AW = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_WALK
    } t_state;

    t_state       r_state;
    t_state       n_state;
    logic [8:0]   r_node;
    logic [8:0]   n_node;
    logic [15:0]  r_count;
    logic [15:0]  n_count;
    logic         r_glyph;
    logic         n_glyph;
    logic         r_done;
    logic         n_done;
    logic [7:0]   r_byte;
    logic [7:0]   n_byte;
    logic [2:0]   r_bit;
    logic [2:0]   n_bit;
    logic         r_oob;

    logic [ENTRY_W-1:0] w_rdata;
    logic [8:0]         w_child;
    logic               w_leaf;
    logic               w_step;
    logic [15:0]        w_cnt_inc;
    logic [7:0]         w_sym;
    logic               w_ovf;
    logic               w_last;
    logic [8:0]         w_rnode;
    logic               w_oob;
    logic               w_we;

    assign w_child   = r_oob ? 9'd0 : (r_byte[r_bit] ? w_rdata[17:9] : w_rdata[8:0]);
    assign w_leaf    = !w_child[8];
    assign w_step    = (r_state == S_WALK) && !i_res_full;
    assign w_cnt_inc = (r_count == COUNT_MAX) ? r_count : 16'(r_count + 16'd1);
    assign w_sym     = w_child[7:0];
    assign w_ovf     = (w_sym != 8'd0) && (w_cnt_inc >= i_max_length);
    assign w_last    = w_ovf || (!r_glyph && (w_sym == 8'd0));

    // The read port always fetches the entry of the node that the next cycle walks from.
    assign w_rnode = w_step ? (w_leaf ? ROOT_NODE : w_child) : r_node;
    assign w_oob   = ({1'b0, w_rnode[7:0]} >= 9'(TREE_NODES));

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd.valid;
    assign w_we      = o_cmd_pop && (i_cmd.cmd.op == OP_TREE)
                       && ({1'b0, i_cmd.cmd.node_slot} < 9'(TREE_NODES));

    assign o_res.valid       = w_step && w_leaf;
    assign o_res.item.symbol = w_sym;
    assign o_res.item.last   = w_last;
    assign o_res.item.status = w_ovf;

    huff_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TREE_NODES)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_cmd.cmd.node_slot[AW-1:0]),
        .i_wdata ({i_cmd.cmd.one_child, i_cmd.cmd.zero_child}),
        .i_raddr (w_rnode[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_node  = r_node;
        n_count = r_count;
        n_glyph = r_glyph;
        n_done  = r_done;
        n_byte  = r_byte;
        n_bit   = r_bit;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.cmd.op)
                        OP_START: begin
                            n_node  = ROOT_NODE;
                            n_count = '0;
                            n_glyph = 1'b0;
                            n_done  = 1'b0;
                        end
                        OP_BYTE: begin
                            if (!r_done) begin
                                n_byte  = i_cmd.cmd.stream_byte;
                                n_bit   = '0;
                                n_state = S_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (w_step) begin
                    n_bit = 3'(r_bit + 1'b1);
                    if (r_bit == 3'd7) begin
                        n_state = S_IDLE;
                    end
                    if (w_leaf) begin
                        n_node  = ROOT_NODE;
                        n_count = w_cnt_inc;
                        if (r_glyph) begin
                            n_glyph = 1'b0;
                        end else if (w_sym > GLYPH_LEAD) begin
                            n_glyph = 1'b1;
                        end
                        if (w_last) begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_node = w_child;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_node  <= ROOT_NODE;
            r_count <= '0;
            r_glyph <= 1'b0;
            r_done  <= 1'b1;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
            r_count <= n_count;
            r_glyph <= n_glyph;
            r_done  <= n_done;
            r_bit   <= n_bit;
        end
        r_byte <= n_byte;
        r_oob  <= w_oob;
    end

endmodule

@@ rtl/huff_outq.sv @@
module huff_outq
    import huff_pkg::*;
    (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_chan i_res,
    output logic      o_res_full,
    output logic      o_empty,
    output t_out_item o_out,
    input  logic      i_pop
    );

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_out_item     r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_res_full = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign w_wr       = i_res.valid && !o_res_full;
    assign w_rd       = i_pop && !o_empty;

    always_comb begin
        unique case ({w_wr, w_rd})
            2'b10: begin
                n_cnt = CW'(r_cnt + 1'b1);
            end
            2'b01: begin
                n_cnt = CW'(r_cnt - 1'b1);
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= PW'(r_wptr + 1'b1);
            end
            if (w_rd) begin
                r_rptr <= PW'(r_rptr + 1'b1);
            end
            r_cnt <= n_cnt;
        end
        if (w_wr) begin
            r_q[r_wptr] <= i_res.item;
        end
    end

    assign o_out = r_q[r_rptr];

endmodule

@@ rtl/huffman_tree_text_decoder.sv @@
// Tree writes and starts take effect in the same cycle as they leave the input queue.
// A stream byte is taken from the input queue, a tree memory read loads the node, then the
// tree is walked one bit per cycle while the result queue is not full, ending early at the
// end of the string. A new stream byte is taken only after the walk of the last one is over.
// Synchronous active-low reset empties both queues, idles the decoder until a start item
// and sets max_length to 65535; tree memory contents are not cleared.
module huffman_tree_text_decoder
    import huff_pkg::*;
    #(
    parameter int TREE_NODES = TREE_NODES_DEF
    )
    (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_in_item    i_in,
    output logic        o_full,
    output logic        o_empty,
    output t_out_item   o_out,
    input  logic        i_pop,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
    );

    logic [15:0] r_max_length;
    t_cmd_chan   w_cmd;
    logic        w_cmd_pop;
    t_res_chan   w_res;
    logic        w_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    huff_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_in      (i_in),
        .o_full    (o_full),
        .o_cmd     (w_cmd),
        .i_cmd_pop (w_cmd_pop)
    );

    huff_walk #(
        .TREE_NODES (TREE_NODES)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_length (r_max_length),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_res        (w_res),
        .i_res_full   (w_res_full)
    );

    huff_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (w_res),
        .o_res_full (w_res_full),
        .o_empty    (o_empty),
        .o_out      (o_out),
        .i_pop      (i_pop)
    );

`ifndef SYNTHESIS
    a_no_res_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> !w_res_full)
        else $error("Decoded symbol offered to a full result queue.");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.status) |-> o_out.last)
        else $error("Overflow status on a symbol that does not end the string.");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("Queues not empty after reset.");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import huff_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 48;
    localparam int N_DIR       = 28;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 42;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_act;

    typedef struct packed {
        t_row_act    act;
        logic [15:0] cfg_val;
        t_in_item    item;
        logic        typed;
        logic        has_res;
        t_out_item   res;
    } t_dir_row;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    t_in_item    in_item;
    logic        full;
    logic        empty;
    t_out_item   out_item;
    logic        pop;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    // Decoder state as seen by the predictor.
    logic [17:0] dec_tree [256];
    logic [8:0]  dec_node;
    logic [15:0] dec_count;
    logic        dec_glyph;
    logic        dec_done;
    logic [15:0] dec_max_len;
    logic [7:0]  tree_slots [$];
    bit          slot_known [256];

    t_out_item   step_syms [$];
    t_out_item   pending_syms [$];
    int          fault_cnt;
    int          cyc_cnt;
    int          hold_req;
    bit          calm;

    // Tree: '0' -> 00, '10' -> 41, '110' -> F5, '111' -> FF, read LSB first.
    t_dir_row dir_tab [N_DIR] = '{
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'hFF}, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_RSVD, 8'hFF, 9'h1FF, 9'h1FF, 8'hFF}, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_TREE, 8'h00, 9'h000, 9'h101, 8'h00}, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_TREE, 8'h01, 9'h041, 9'h102, 8'h00}, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_TREE, 8'h02, 9'h0F5, 9'h0FF, 8'h00}, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_TREE, 8'hFF, 9'h1FF, 9'h100, 8'h00}, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_START, 8'h00, 9'h000, 9'h000, 8'h00}, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'h02}, 1'b1, 1'b1,
          {8'h00, 1'b1, 1'b0}},
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'h05}, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_START, 8'h00, 9'h000, 9'h000, 8'h00}, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'h01}, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_START, 8'h00, 9'h000, 9'h000, 8'h00}, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'h03}, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_START, 8'h00, 9'h000, 9'h000, 8'h00}, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'hFF}, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'h00}, 1'b0, 1'b0, '0},
        '{ROW_CFG, 16'd1, '0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_START, 8'h00, 9'h000, 9'h000, 8'h00}, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'h01}, 1'b1, 1'b1,
          {8'h41, 1'b1, 1'b1}},
        '{ROW_CFG, 16'd2, '0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_START, 8'h00, 9'h000, 9'h000, 8'h00}, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'h13}, 1'b0, 1'b0, '0},
        '{ROW_CFG, 16'd0, '0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_START, 8'h00, 9'h000, 9'h000, 8'h00}, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'h02}, 1'b1, 1'b1,
          {8'h00, 1'b1, 1'b0}},
        '{ROW_ITEM, 16'd0, {KIND_START, 8'h00, 9'h000, 9'h000, 8'h00}, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 16'd0, {KIND_BYTE, 8'h00, 9'h000, 9'h000, 8'h01}, 1'b1, 1'b1,
          {8'h41, 1'b1, 1'b1}},
        '{ROW_CFG, 16'hFFFF, '0, 1'b0, 1'b0, '0}
    };

    huffman_tree_text_decoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_in        (in_item),
        .o_full      (full),
        .o_empty     (empty),
        .o_out       (out_item),
        .i_pop       (pop),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    task automatic decode_step(input t_in_item it);
        logic [8:0] nxt;
        logic [7:0] sym;
        logic       lst;
        logic       ovf;
        step_syms.delete();
        case (it.kind)
            KIND_TREE: begin
                dec_tree[it.node_slot] = {it.one_child, it.zero_child};
                if (!slot_known[it.node_slot]) begin
                    slot_known[it.node_slot] = 1'b1;
                    tree_slots.push_back(it.node_slot);
                end
            end
            KIND_START: begin
                dec_node  = ROOT_NODE;
                dec_count = '0;
                dec_glyph = 1'b0;
                dec_done  = 1'b0;
            end
            KIND_BYTE: begin
                for (int b = 0; b < 8 && !dec_done; b++) begin
                    nxt = it.stream_byte[b] ? dec_tree[dec_node[7:0]][17:9]
                                            : dec_tree[dec_node[7:0]][8:0];
                    if (nxt >= ROOT_NODE) begin
                        dec_node = nxt;
                    end else begin
                        dec_node = ROOT_NODE;
                        sym = nxt[7:0];
                        lst = 1'b0;
                        ovf = 1'b0;
                        if (dec_count != COUNT_MAX) begin
                            dec_count = dec_count + 16'd1;
                        end
                        if (dec_glyph) begin
                            dec_glyph = 1'b0;
                        end else if (sym > GLYPH_LEAD) begin
                            dec_glyph = 1'b1;
                        end else if (sym == 8'h00) begin
                            lst = 1'b1;
                        end
                        // A zero never overflows, even when it completes a glyph at the limit.
                        if (sym != 8'h00 && dec_count >= dec_max_len) begin
                            lst = 1'b1;
                            ovf = 1'b1;
                        end
                        if (lst) begin
                            dec_done = 1'b1;
                        end
                        step_syms.push_back('{symbol: sym, last: lst, status: ovf});
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send(input t_in_item it, input bit use_pred);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (full);
        decode_step(it);
        if (use_pred) begin
            foreach (step_syms[k]) pending_syms.push_back(step_syms[k]);
        end
    endtask

    task automatic write_max_len(input logic [15:0] v);
        push <= 1'b0;
        while (pending_syms.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        dec_max_len = v;
    endtask

    function automatic logic [8:0] rand_leaf();
        case ($urandom_range(0, 7))
            0: return 9'h000;
            1: return 9'($urandom_range(32'(GLYPH_LEAD), 255));
            default: return 9'($urandom_range(0, 255));
        endcase
    endfunction

    // Internal children only point at written nodes, so no walk reads an empty entry.
    function automatic logic [8:0] rand_child();
        if ($urandom_range(0, 1) == 0 || tree_slots.size() == 0) begin
            return rand_leaf();
        end
        return {1'b1, tree_slots[$urandom_range(0, tree_slots.size() - 1)]};
    endfunction

    function automatic t_in_item rand_item(input logic [1:0] k);
        t_in_item it;
        it.kind        = k;
        it.node_slot   = 8'($urandom);
        it.zero_child  = 9'($urandom);
        it.one_child   = 9'($urandom);
        it.stream_byte = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_tree_item();
        t_in_item it;
        it            = rand_item(KIND_TREE);
        it.node_slot  = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        it.zero_child = rand_child();
        it.one_child  = rand_child();
        return it;
    endfunction

    initial begin : result_side
        int        gap;
        t_out_item want;
        pop = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_req > 0) begin
                pop <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            if (pending_syms.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10) begin
                    $display("unexpected result: symbol %h last %b stat %b",
                             out_item.symbol, out_item.last, out_item.status);
                end
            end else begin
                want = pending_syms.pop_front();
                if (out_item.symbol !== want.symbol || out_item.last !== want.last ||
                    out_item.status !== want.status) begin
                    fault_cnt++;
                    if (fault_cnt <= 10) begin
                        $display("mismatch: symbol %h/%h last %b/%b stat %b/%b (exp/act)",
                                 want.symbol, out_item.symbol, want.last, out_item.last,
                                 want.status, out_item.status);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cyc_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cyc_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int          counted;
        int          roll;
        logic [15:0] new_len;
        rst_n       = 1'b0;
        push        = 1'b0;
        in_item     = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        fault_cnt   = 0;
        hold_req    = 0;
        calm        = 1'b0;
        dec_node    = ROOT_NODE;
        dec_count   = '0;
        dec_glyph   = 1'b0;
        dec_done    = 1'b1;
        dec_max_len = MAX_LENGTH_RST;
        foreach (dec_tree[i]) begin
            dec_tree[i]   = '0;
            slot_known[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].act == ROW_CFG) begin
                write_max_len(dir_tab[i].cfg_val);
            end else begin
                send(dir_tab[i].item, !dir_tab[i].typed);
                if (dir_tab[i].typed && dir_tab[i].has_res) begin
                    pending_syms.push_back(dir_tab[i].res);
                end
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: new_len = 16'hFFFF;
                1: new_len = 16'($urandom_range(2, 12));
                2: new_len = 16'd1;
                3: new_len = 16'($urandom_range(13, 65534));
                4: new_len = 16'($urandom_range(3, 8));
                default: new_len = 16'hFFFF;
            endcase
            write_max_len(new_len);
            calm = (ph == 4);
            // Long result-side stall while items keep coming, so the block backs up.
            if (ph == 1) begin
                hold_req = 300;
            end
            counted = 0;
            repeat (3) begin
                send(make_tree_item(), 1'b1);
                counted++;
            end
            while (counted < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (dec_done && roll < 75) begin
                    send(rand_item(KIND_START), 1'b1);
                end else if (roll < 8) begin
                    send(make_tree_item(), 1'b1);
                end else if (roll < 11) begin
                    send(rand_item(KIND_START), 1'b1);
                end else if (roll < 14) begin
                    send(rand_item(KIND_RSVD), 1'b1);
                end else begin
                    send(rand_item(KIND_BYTE), 1'b1);
                end
                counted++;
            end
        end
        calm = 1'b0;
        push <= 1'b0;

        for (int w = 0; w < 20000 && pending_syms.size() != 0; w++) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        fault_cnt += pending_syms.size();
        if (fault_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ huffman_tree_text_decoder.f @@
rtl/huff_pkg.sv
rtl/huff_ram.sv
rtl/huff_front.sv
rtl/huff_walk.sv
rtl/huff_outq.sv
rtl/huffman_tree_text_decoder.sv
sim/tb.sv
